/* sv/refpa_pkg.sv */
// Package holding the field types, request codes and status codes of the page allocator.
`timescale 1ns / 1ps
`default_nettype none

package refpa_pkg;

    localparam int PAGE_W   = 15;
    localparam int TYPE_W   = 2;
    localparam int STATUS_W = 3;
    localparam int FREE_W   = 16;

    typedef logic [PAGE_W-1:0]   page_t;
    typedef logic [TYPE_W-1:0]   req_type_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [FREE_W-1:0]   free_t;

    // Request codes.
    localparam req_type_t REQ_ALLOC = 2'd0;
    localparam req_type_t REQ_FREE  = 2'd1;
    localparam req_type_t REQ_SHARE = 2'd2;

    // Result status codes.
    localparam status_t STATUS_OK        = 3'd0;
    localparam status_t STATUS_NO_FREE   = 3'd1;
    localparam status_t STATUS_BAD_PAGE  = 3'd2;
    localparam status_t STATUS_SHARED    = 3'd3;
    localparam status_t STATUS_OVERFLOW  = 3'd4;
    localparam status_t STATUS_SATURATED = 3'd5;

endpackage

`default_nettype wire

/* sv/refpa_ifs.sv */
// Interfaces for the request, result and configuration channels of the page allocator.
`timescale 1ns / 1ps
`default_nettype none

interface refpa_req_if;
    logic                  valid;
    logic                  ready;
    refpa_pkg::req_type_t  req_type;
    refpa_pkg::page_t      page_number;

    modport source (output valid, output req_type, output page_number, input ready);
    modport sink   (input valid, input req_type, input page_number, output ready);
endinterface

interface refpa_rsp_if;
    logic                valid;
    logic                ready;
    refpa_pkg::page_t    page_out;
    refpa_pkg::status_t  status;
    refpa_pkg::free_t    avail_pages;

    modport source (output valid, output page_out, output status, output avail_pages,
                    input ready);
    modport sink   (input valid, input page_out, input status, input avail_pages,
                    output ready);
endinterface

interface refpa_cfg_if;
    logic              valid;
    logic              ready;
    refpa_pkg::page_t  first_free_page;

    modport source (output valid, output first_free_page, input ready);
    modport sink   (input valid, input first_free_page, output ready);
endinterface

`default_nettype wire

/* sv/refcounted_page_allocator.sv */
// Top level of the reference-counted page allocator with its stack and share-count memories.
`timescale 1ns / 1ps
`default_nettype none

// The allocator hands out page numbers from first_free_page up to the page limit, which is
// the smaller of TOTAL_PAGES and 32768, and keeps a share count of COUNT_BITS per page for
// copy-on-write. Freed pages go on a last-in first-out stack held in a memory with one
// write port and one read port; when the stack is empty, pages that have never been handed
// out are given from the top downward. When a request is taken, the stack slot and the
// page's share count are read from their memories; in the execute state the result is
// worked out, the memories and counters are written back and the result is loaded into the
// output register. A new request is taken while a finished result still waits in that
// register, but a second result must wait until the first has been transferred. After reset
// the share-count memory is cleared one entry per cycle, over as many entries as the page
// limit (32768 with the default parameters); no request is taken during that pass, whereas
// writes to first_free_page are taken at any time. Writing first_free_page recomputes the
// free-page count and should only be done while no request is in flight.
module refcounted_page_allocator #(
    parameter int TOTAL_PAGES = 32768,
    parameter int COUNT_BITS  = 8
) (
    input  wire          clk,
    input  wire          rst_n,
    refpa_cfg_if.sink    cfg,
    refpa_req_if.sink    req,
    refpa_rsp_if.source  rsp
);

    import refpa_pkg::*;

    localparam int PAGE_LIMIT = (TOTAL_PAGES < 32768) ? TOTAL_PAGES : 32768;
    localparam int ADDR_W     = (PAGE_LIMIT > 1) ? $clog2(PAGE_LIMIT) : 1;
    localparam int CNT_W      = $clog2(PAGE_LIMIT + 1);
    localparam int EXT_W      = 17;

    localparam logic [CNT_W-1:0]      LIMIT_CNT  = CNT_W'(PAGE_LIMIT);
    localparam logic [EXT_W-1:0]      LIMIT_EXT  = EXT_W'(PAGE_LIMIT);
    localparam logic [ADDR_W-1:0]     LAST_ADDR  = ADDR_W'(PAGE_LIMIT - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;

    // Sequencer states.
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clear_idx_reg;

    page_t             first_free_page_reg;
    logic [CNT_W-1:0]  stack_depth_reg, stack_depth_next;
    logic [CNT_W-1:0]  untouched_mark_reg, untouched_mark_next;
    logic [CNT_W-1:0]  free_count_reg, free_count_next;
    logic [CNT_W-1:0]  cfg_free_count;

    req_type_t         req_type_reg;
    page_t             page_reg;

    // Memories: the free stack and the per-page share counts.
    page_t                  stack_mem [PAGE_LIMIT];
    logic [COUNT_BITS-1:0]  share_mem [PAGE_LIMIT];
    page_t                  stack_rdata_reg;
    logic [COUNT_BITS-1:0]  share_rdata_reg;

    logic                   stack_we;
    logic                   share_we;
    logic [ADDR_W-1:0]      share_waddr;
    logic [COUNT_BITS-1:0]  share_wdata;
    logic [COUNT_BITS-1:0]  share_upd;

    logic                   rsp_valid_reg;
    page_t                  rsp_page_reg,   res_page;
    status_t                rsp_status_reg, res_status;
    free_t                  rsp_free_reg;

    logic              req_fire;
    logic              exec_fire;
    logic [CNT_W-1:0]  depth_m1;
    logic [CNT_W-1:0]  mark_m1;
    logic [EXT_W-1:0]  ffp_ext, cfg_ffp_ext, page_ext, mark_ext, fc_ext;
    logic              page_ok;
    logic              overflow;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign req_fire  = req.valid && req.ready;

    // The execute state of a request completes only when the output register is empty or being transferred.
    assign exec_fire = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);

    assign depth_m1    = stack_depth_reg - 1'b1;
    assign mark_m1     = untouched_mark_reg - 1'b1;
    assign ffp_ext     = EXT_W'(first_free_page_reg);
    assign cfg_ffp_ext = EXT_W'(cfg.first_free_page);
    assign page_ext    = EXT_W'(page_reg);
    assign mark_ext    = EXT_W'(untouched_mark_reg);
    assign fc_ext      = EXT_W'(free_count_reg);

    assign page_ok  = (page_ext >= ffp_ext) && (page_ext < LIMIT_EXT);

    // A free is refused when the count would pass the number of allocatable pages or the
    // stack is full. A first_free_page above the limit leaves only the stack-full cap.
    assign overflow = ((ffp_ext <= LIMIT_EXT) && (fc_ext >= LIMIT_EXT - ffp_ext))
                   || (stack_depth_reg >= LIMIT_CNT);

    // Free count after a configuration write: stacked pages plus untouched pages at or
    // above the new first_free_page.
    always_comb
    begin
        if (mark_ext > cfg_ffp_ext)
        begin
            cfg_free_count = stack_depth_reg + CNT_W'(mark_ext - cfg_ffp_ext);
        end
        else
        begin
            cfg_free_count = stack_depth_reg;
        end
    end

    // Decision logic for the execute state of a request, using the registered memory reads.
    always_comb
    begin
        stack_depth_next    = stack_depth_reg;
        untouched_mark_next = untouched_mark_reg;
        free_count_next     = free_count_reg;
        stack_we            = 1'b0;
        share_upd           = share_rdata_reg;
        res_page            = '0;
        res_status          = STATUS_OK;
        share_we            = 1'b0;
        case (req_type_reg)
            REQ_ALLOC:
            begin
                if (stack_depth_reg != '0)
                begin
                    stack_depth_next = depth_m1;
                    free_count_next  = free_count_reg - 1'b1;
                    res_page         = stack_rdata_reg;
                end
                else if (mark_ext > ffp_ext)
                begin
                    untouched_mark_next = mark_m1;
                    free_count_next     = free_count_reg - 1'b1;
                    res_page            = PAGE_W'(mark_m1);
                end
                else
                begin
                    res_status = STATUS_NO_FREE;
                end
            end
            REQ_FREE:
            begin
                if (!page_ok)
                begin
                    res_status = STATUS_BAD_PAGE;
                end
                else if (share_rdata_reg != '0)
                begin
                    share_we   = 1'b1;
                    share_upd  = share_rdata_reg - 1'b1;
                    res_status = STATUS_SHARED;
                end
                else if (overflow)
                begin
                    res_status = STATUS_OVERFLOW;
                end
                else
                begin
                    stack_we         = 1'b1;
                    stack_depth_next = stack_depth_reg + 1'b1;
                    free_count_next  = free_count_reg + 1'b1;
                end
            end
            REQ_SHARE:
            begin
                if (!page_ok)
                begin
                    res_status = STATUS_BAD_PAGE;
                end
                else if (share_rdata_reg == COUNT_MAX)
                begin
                    res_status = STATUS_SATURATED;
                end
                else
                begin
                    share_we  = 1'b1;
                    share_upd = share_rdata_reg + 1'b1;
                end
            end
            default:
            begin
                // The reserved request type changes nothing.
                res_status = STATUS_OK;
            end
        endcase
    end

    // During the clearing pass the share memory is written with zero at the sweep index.
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            share_waddr = clear_idx_reg;
            share_wdata = '0;
        end
        else
        begin
            share_waddr = page_reg[ADDR_W-1:0];
            share_wdata = share_upd;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clear_idx_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Stack memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (exec_fire && stack_we)
        begin
            stack_mem[stack_depth_reg[ADDR_W-1:0]] <= page_reg;
        end
        if (req_fire)
        begin
            stack_rdata_reg <= stack_mem[depth_m1[ADDR_W-1:0]];
        end
    end

    // Share-count memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_CLEAR) || (exec_fire && share_we))
        begin
            share_mem[share_waddr] <= share_wdata;
        end
        if (req_fire)
        begin
            share_rdata_reg <= share_mem[req.page_number[ADDR_W-1:0]];
        end
    end

    // Captured request and result payload.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_type_reg <= req.req_type;
            page_reg     <= req.page_number;
        end
        if (exec_fire)
        begin
            rsp_page_reg   <= res_page;
            rsp_status_reg <= res_status;
            rsp_free_reg   <= FREE_W'(free_count_next);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_CLEAR;
            clear_idx_reg       <= '0;
            first_free_page_reg <= '0;
            stack_depth_reg     <= '0;
            untouched_mark_reg  <= LIMIT_CNT;
            free_count_reg      <= LIMIT_CNT;
            rsp_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clear_idx_reg <= clear_idx_reg + 1'b1;
            end
            if (cfg.valid && cfg.ready)
            begin
                first_free_page_reg <= cfg.first_free_page;
                free_count_reg      <= cfg_free_count;
            end
            else if (exec_fire)
            begin
                free_count_reg <= free_count_next;
            end
            if (exec_fire)
            begin
                stack_depth_reg    <= stack_depth_next;
                untouched_mark_reg <= untouched_mark_next;
                rsp_valid_reg      <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.page_out    = rsp_page_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.avail_pages = rsp_free_reg;

endmodule

`default_nettype wire
